// File: sv/uqm_pkg.sv
// ============================================================================
// User quota meter table package
// Shared widths, codes and record layouts for the per-user accounting table.
// ============================================================================
`default_nettype none

package uqm_pkg;

    // Table size and field widths.
    localparam int USERS_DEFAULT = 1024;
    localparam int OP_W          = 3;
    localparam int SLOT_W        = 10;
    localparam int TIME_W        = 32;
    localparam int LEN_W         = 16;
    localparam int HDR_W         = 4;
    localparam int STATUS_W      = 2;
    localparam int BYTES_W       = 64;
    localparam int COUNT_W       = 32;
    localparam int VERDICT_W     = 2;
    localparam int CAUSE_W       = 3;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;

    // Configuration register reset values.
    localparam logic [TIME_W-1:0] LIFETIME_RESET = TIME_W'(5*24*60*60);
    localparam logic [TIME_W-1:0] IDLE_RESET     = TIME_W'(30*60);
    localparam logic [LEN_W-1:0]  WORD_BYTES     = LEN_W'(4);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE     = 1'd1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_UP     = 3'd1;
    localparam logic [OP_W-1:0] OP_DOWN   = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OP_W-1:0] OP_SWEEP  = 3'd4;

    // Entry status codes; the remaining codes mean blocked.
    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ACCT = 2'd1;

    // Verdict codes.
    localparam logic [VERDICT_W-1:0] VERDICT_PASS  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_DROP  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_EMPTY = 2'd2;

    // Removal causes.
    localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_QUOTA    = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_LIFETIME = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_IDLE     = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_HOST     = 3'd4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic                status_lim_flow;
        logic                status_lim_time;
        logic [STATUS_W-1:0] status;
    } t_mode;

    // One table entry. The byte total is kept alongside the two byte
    // counters; a packet update adds its payload to one counter and to the total.
    typedef struct packed {
        logic [TIME_W-1:0]  start_time;
        logic [TIME_W-1:0]  last_active_time;
        logic [BYTES_W-1:0] up_bytes;
        logic [BYTES_W-1:0] down_bytes;
        logic [BYTES_W-1:0] byte_total;
        logic [COUNT_W-1:0] up_packets;
        logic [COUNT_W-1:0] down_packets;
        logic [COUNT_W-1:0] up_drops;
        logic [COUNT_W-1:0] down_drops;
        t_mode              acct_mode;
        logic [TIME_W-1:0]  time_quota;
        logic [BYTES_W-1:0] flow_quota;
    } t_entry;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SLOT_W-1:0]   slot;
        logic [TIME_W-1:0]   now_seconds;
        logic                is_ipv4;
        logic [LEN_W-1:0]    ip_total_length;
        logic [HDR_W-1:0]    ip_header_words;
        logic [STATUS_W-1:0] new_status;
        logic                new_limit_by_time;
        logic                new_limit_by_flow;
        logic [TIME_W-1:0]   new_time_quota;
        logic [BYTES_W-1:0]  new_flow_quota;
    } t_item;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic                 removed;
        logic [CAUSE_W-1:0]   remove_cause;
        logic [BYTES_W-1:0]   byte_total;
    } t_result;

    // Write-back control from the update logic to the table.
    typedef struct packed {
        logic valid_we;
        logic valid_data;
        logic entry_we;
    } t_wr_ctrl;

endpackage

`default_nettype wire

// File: sv/user_quota_meter_table.sv
// ============================================================================
// User quota meter table
// Per-user accounting table with time and byte quotas, idle and lifetime
// sweep, and host removal.
// ============================================================================
// For each item the slot is first read from the entry memory; in the update
// state the entry is then updated, written back and the result loaded into
// the output register, with a single memory read and write per item. A
// stalled output holds the item in the update state until the finished
// result can be handed on. A new item is taken while the previous result
// still waits in the output register, but not before the last item's update
// is done. After reset the block runs a clearing pass over the valid bits,
// one slot per cycle, during which it stalls its input; configuration writes
// are taken at all times and should only be issued while the block is idle.
`default_nettype none

module user_quota_meter_table #(
    parameter int USERS = uqm_pkg::USERS_DEFAULT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    input  wire logic                               i_cfg_we,
    input  wire logic [uqm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [uqm_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [uqm_pkg::OP_W-1:0]           i_op,
    input  wire logic [uqm_pkg::SLOT_W-1:0]         i_slot,
    input  wire logic [uqm_pkg::TIME_W-1:0]         i_now_seconds,
    input  wire logic                               i_is_ipv4,
    input  wire logic [uqm_pkg::LEN_W-1:0]          i_ip_total_length,
    input  wire logic [uqm_pkg::HDR_W-1:0]          i_ip_header_words,
    input  wire logic [uqm_pkg::STATUS_W-1:0]       i_new_status,
    input  wire logic                               i_new_limit_by_time,
    input  wire logic                               i_new_limit_by_flow,
    input  wire logic [uqm_pkg::TIME_W-1:0]         i_new_time_quota,
    input  wire logic [uqm_pkg::BYTES_W-1:0]        i_new_flow_quota,

    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [uqm_pkg::VERDICT_W-1:0]           o_verdict,
    output logic                                    o_removed,
    output logic [uqm_pkg::CAUSE_W-1:0]             o_remove_cause,
    output logic [uqm_pkg::BYTES_W-1:0]             o_byte_total
);
    import uqm_pkg::*;

    localparam int AW = $clog2(USERS);

    t_state            r_state;
    t_state            n_state;
    logic [AW-1:0]     r_clr_idx;
    logic [TIME_W-1:0] r_lifetime_limit;
    logic [TIME_W-1:0] r_idle_limit;
    t_item             r_item;
    logic              r_out_valid;
    t_result           r_out;

    logic              accept;
    logic              fire;
    logic              clearing;
    logic              out_free;
    logic              clr_last;

    logic              rd_valid;
    t_entry            rd_entry;
    t_entry            new_entry;
    t_wr_ctrl          upd_wr;
    t_result           upd_result;
    t_wr_ctrl          tbl_wr;
    logic [AW-1:0]     tbl_wr_addr;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime_limit <= LIFETIME_RESET;
            r_idle_limit     <= IDLE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LIFETIME: r_lifetime_limit <= TIME_W'(i_cfg_data);
                CFG_IDLE:     r_idle_limit     <= TIME_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control sequencer: clearing pass, then alternate read and update.
    // ------------------------------------------------------------------
    assign out_free = !r_out_valid || !i_out_stall;
    assign clr_last = (r_clr_idx == AW'(USERS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (clr_last)   n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_EXEC;
            ST_EXEC:  if (out_free)   n_state = ST_IDLE;
            default:                  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        accept     = 1'b0;
        fire       = 1'b0;
        clearing   = 1'b0;
        unique case (r_state)
            ST_CLEAR: clearing = 1'b1;
            ST_IDLE: begin
                o_in_stall = 1'b0;
                accept     = i_in_valid;
            end
            ST_EXEC:  fire = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // The accepted transfer is held for the update cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op                <= i_op;
            r_item.slot              <= i_slot;
            r_item.now_seconds       <= i_now_seconds;
            r_item.is_ipv4           <= i_is_ipv4;
            r_item.ip_total_length   <= i_ip_total_length;
            r_item.ip_header_words   <= i_ip_header_words;
            r_item.new_status        <= i_new_status;
            r_item.new_limit_by_time <= i_new_limit_by_time;
            r_item.new_limit_by_flow <= i_new_limit_by_flow;
            r_item.new_time_quota    <= i_new_time_quota;
            r_item.new_flow_quota    <= i_new_flow_quota;
        end
    end

    // ------------------------------------------------------------------
    // Table write port: the clearing pass owns it until it finishes; after
    // that only the update cycle writes, and only when its result leaves.
    // ------------------------------------------------------------------
    always_comb begin
        if (clearing) begin
            tbl_wr.valid_we   = 1'b1;
            tbl_wr.valid_data = 1'b0;
            tbl_wr.entry_we   = 1'b0;
            tbl_wr_addr       = r_clr_idx;
        end else begin
            tbl_wr.valid_we   = fire && upd_wr.valid_we;
            tbl_wr.valid_data = upd_wr.valid_data;
            tbl_wr.entry_we   = fire && upd_wr.entry_we;
            tbl_wr_addr       = AW'(r_item.slot);
        end
    end

    uqm_table #(
        .USERS(USERS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rd_en    (accept),
        .i_rd_addr  (AW'(i_slot)),
        .i_wr_addr  (tbl_wr_addr),
        .i_wr       (tbl_wr),
        .i_wr_entry (new_entry),
        .o_rd_valid (rd_valid),
        .o_rd_entry (rd_entry)
    );

    uqm_update #(
        .USERS(USERS)
    ) u_update (
        .i_item           (r_item),
        .i_entry_valid    (rd_valid),
        .i_entry          (rd_entry),
        .i_lifetime_limit (r_lifetime_limit),
        .i_idle_limit     (r_idle_limit),
        .o_new_entry      (new_entry),
        .o_wr             (upd_wr),
        .o_result         (upd_result)
    );

    // ------------------------------------------------------------------
    // Output register. A new result loads only when the slot is empty or
    // the waiting result is taken in the same cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= upd_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_out.verdict;
    assign o_removed      = r_out.removed;
    assign o_remove_cause = r_out.remove_cause;
    assign o_byte_total   = r_out.byte_total;

endmodule

`default_nettype wire

// File: sv/uqm_table.sv
// ============================================================================
// User quota meter table storage
// Valid-bit memory and entry memory, one synchronous read port each with a
// registered read, and one write port each.
// ============================================================================
`default_nettype none

module uqm_table #(
    parameter int USERS = uqm_pkg::USERS_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rd_en,
    input  wire logic [$clog2(USERS)-1:0]   i_rd_addr,
    input  wire logic [$clog2(USERS)-1:0]   i_wr_addr,
    input  wire uqm_pkg::t_wr_ctrl          i_wr,
    input  wire uqm_pkg::t_entry            i_wr_entry,
    output logic                            o_rd_valid,
    output uqm_pkg::t_entry                 o_rd_entry
);
    import uqm_pkg::*;

    logic   r_valid_mem [USERS];
    t_entry r_entry_mem [USERS];
    logic   r_rd_valid;
    t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr.valid_we) begin
            r_valid_mem[i_wr_addr] <= i_wr.valid_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.entry_we) begin
            r_entry_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    // Read data holds until the next read, so a stalled item keeps it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_valid <= r_valid_mem[i_rd_addr];
            r_rd_entry <= r_entry_mem[i_rd_addr];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_entry = r_rd_entry;

endmodule

`default_nettype wire

// File: sv/uqm_update.sv
// ============================================================================
// User quota meter update logic
// Computes the new entry, the write-back control and the result of one item.
// ============================================================================
`default_nettype none

module uqm_update #(
    parameter int USERS = uqm_pkg::USERS_DEFAULT
) (
    input  wire uqm_pkg::t_item                         i_item,
    input  wire logic                                   i_entry_valid,
    input  wire uqm_pkg::t_entry                        i_entry,
    input  wire logic [uqm_pkg::TIME_W-1:0]             i_lifetime_limit,
    input  wire logic [uqm_pkg::TIME_W-1:0]             i_idle_limit,
    output uqm_pkg::t_entry                             o_new_entry,
    output uqm_pkg::t_wr_ctrl                           o_wr,
    output uqm_pkg::t_result                            o_result
);
    import uqm_pkg::*;

    logic               in_range;
    logic [LEN_W-1:0]   hdr_bytes;
    logic [LEN_W-1:0]   payload;
    logic [TIME_W-1:0]  age;
    logic [TIME_W-1:0]  idle_age;
    logic               by_time;
    logic               by_flow;
    t_entry             nxt;
    t_wr_ctrl           wr;
    t_result            res;

    assign in_range  = 32'(i_item.slot) < 32'(USERS);
    assign hdr_bytes = LEN_W'(i_item.ip_header_words) * WORD_BYTES;
    assign payload   = (i_item.ip_total_length > hdr_bytes) ?
                       (i_item.ip_total_length - hdr_bytes) : '0;
    assign age       = i_item.now_seconds - i_entry.start_time;
    assign idle_age  = i_item.now_seconds - i_entry.last_active_time;

    always_comb begin
        nxt     = i_entry;
        wr      = '0;
        res     = '0;
        by_time = 1'b0;
        by_flow = 1'b0;
        unique case (i_item.op) inside
            OP_ADD: begin
                if (!in_range) begin
                    res.verdict = VERDICT_EMPTY;
                end else begin
                    nxt.start_time                = i_item.now_seconds;
                    nxt.last_active_time          = i_item.now_seconds;
                    nxt.up_bytes                  = '0;
                    nxt.down_bytes                = '0;
                    nxt.byte_total                = '0;
                    nxt.up_packets                = '0;
                    nxt.down_packets              = '0;
                    nxt.up_drops                  = '0;
                    nxt.down_drops                = '0;
                    nxt.acct_mode.status          = i_item.new_status;
                    nxt.acct_mode.status_lim_time = i_item.new_limit_by_time;
                    nxt.acct_mode.status_lim_flow = i_item.new_limit_by_flow;
                    nxt.time_quota                = i_item.new_time_quota;
                    nxt.flow_quota                = i_item.new_flow_quota;
                    wr.valid_we   = 1'b1;
                    wr.valid_data = 1'b1;
                    wr.entry_we   = 1'b1;
                end
            end
            OP_UP, OP_DOWN, OP_REMOVE, OP_SWEEP: begin
                if (!in_range || !i_entry_valid) begin
                    res.verdict = VERDICT_EMPTY;
                end else if (i_item.op == OP_REMOVE) begin
                    res.byte_total   = i_entry.byte_total;
                    res.removed      = 1'b1;
                    res.remove_cause = CAUSE_HOST;
                    wr.valid_we      = 1'b1;
                end else if (i_item.op == OP_SWEEP) begin
                    res.byte_total = i_entry.byte_total;
                    if (age >= i_lifetime_limit) begin
                        res.removed      = 1'b1;
                        res.remove_cause = CAUSE_LIFETIME;
                        wr.valid_we      = 1'b1;
                    end else if (idle_age >= i_idle_limit) begin
                        res.removed      = 1'b1;
                        res.remove_cause = CAUSE_IDLE;
                        wr.valid_we      = 1'b1;
                    end
                end else if (i_item.op == OP_UP && !i_item.is_ipv4) begin
                    res.byte_total = i_entry.byte_total;
                end else begin
                    if (i_item.op == OP_UP) begin
                        nxt.up_packets = i_entry.up_packets + 1'b1;
                        nxt.up_bytes   = i_entry.up_bytes + BYTES_W'(payload);
                    end else begin
                        nxt.down_packets = i_entry.down_packets + 1'b1;
                        nxt.down_bytes   = i_entry.down_bytes + BYTES_W'(payload);
                    end
                    nxt.byte_total       = i_entry.byte_total + BYTES_W'(payload);
                    nxt.last_active_time = i_item.now_seconds;
                    res.byte_total       = nxt.byte_total;
                    wr.entry_we          = 1'b1;
                    if (i_entry.acct_mode.status == STATUS_ACCT) begin
                        by_time = i_entry.acct_mode.status_lim_time &&
                                  (age >= i_entry.time_quota);
                        by_flow = i_entry.acct_mode.status_lim_flow &&
                                  (nxt.byte_total >= i_entry.flow_quota);
                        if (by_time || by_flow) begin
                            res.removed      = 1'b1;
                            res.remove_cause = CAUSE_QUOTA;
                            wr.valid_we      = 1'b1;
                        end
                    end else if (i_entry.acct_mode.status != STATUS_NONE) begin
                        // Blocked user: the packet is still metered, then dropped.
                        if (i_item.op == OP_UP) begin
                            nxt.up_drops = i_entry.up_drops + 1'b1;
                        end else begin
                            nxt.down_drops = i_entry.down_drops + 1'b1;
                        end
                        res.verdict = VERDICT_DROP;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_new_entry = nxt;
    assign o_wr        = wr;
    assign o_result    = res;

endmodule

`default_nettype wire
